// ===== rtl/core/rrt_pkg.sv =====
// Shared types, character codes and helpers for the request tokenizer.
// No dependencies; imported by rrt_num_line and resp_request_tokenizer.
package rrt_pkg;

    localparam int COUNT_BITS_DEF = 31;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Bytes dropped after each bulk payload (its CR LF, not checked).
    localparam logic [1:0] SKIP_BYTES = 2'd2;

    // Position inside a count or length line.
    typedef enum logic [1:0] {
        SUB_LEAD,
        SUB_SIGN,
        SUB_DIG,
        SUB_JUNK
    } t_sub;

    typedef struct packed {
        logic cr_seen;
        logic negative;
        logic digits;
    } t_line_flags;

    typedef struct packed {
        logic done;   // CR LF closed the line on this byte
        logic bad;    // no digits, or value out of range
        logic zero;   // magnitude is zero
    } t_line_stat;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

// ===== rtl/core/rrt_num_line.sv =====
// Decimal line reader: one byte of a count or length line per call.
// Depends on rrt_pkg for character codes, t_sub and the flag structs.
module rrt_num_line import rrt_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic [7:0]          i_byte,
    input  t_sub                i_sub,
    input  t_line_flags         i_flags,
    input  logic [COUNT_BITS:0] i_value,
    output t_sub                o_sub,
    output t_line_flags         o_flags,
    output logic [COUNT_BITS:0] o_value,
    output t_line_stat          o_stat
);

    localparam int VAL_W  = COUNT_BITS + 1;
    localparam int PROD_W = VAL_W + 3;

    // Magnitude saturates one past the most negative legal value.
    localparam logic [VAL_W-1:0] MagCap   = {1'b1, {(COUNT_BITS-1){1'b0}}, 1'b1};
    localparam logic [VAL_W-1:0] PosLimit = {1'b0, {COUNT_BITS{1'b1}}};
    localparam logic [VAL_W-1:0] NegLimit = {1'b1, {COUNT_BITS{1'b0}}};

    logic              feed_en;
    t_sub              feed_sub;
    logic              is_digit;
    logic [PROD_W-1:0] prod;

    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign prod = {i_value, 3'b000} + {2'b00, i_value, 1'b0}
                + {{(PROD_W-4){1'b0}}, i_byte[3:0]};

    always_comb begin
        feed_en          = 1'b0;
        feed_sub         = i_sub;
        o_flags          = i_flags;
        o_value          = i_value;
        o_sub            = i_sub;
        o_stat.done      = 1'b0;
        o_stat.bad       = !i_flags.digits
                         || (i_flags.negative ? (i_value > NegLimit) : (i_value > PosLimit));
        o_stat.zero      = (i_value == '0);

        if (i_flags.cr_seen) begin
            if (i_byte == CH_LF) begin
                o_stat.done     = 1'b1;
                o_flags.cr_seen = 1'b0;
            end else begin
                // The held CR was an ordinary character after all.
                feed_sub = (i_sub == SUB_LEAD) ? SUB_LEAD : SUB_JUNK;
                if (i_byte != CH_CR) begin
                    o_flags.cr_seen = 1'b0;
                    feed_en         = 1'b1;
                end
            end
        end else if (i_byte == CH_CR) begin
            o_flags.cr_seen = 1'b1;
        end else begin
            feed_en = 1'b1;
        end

        if (!o_stat.done) begin
            o_sub = feed_sub;
        end
        if (feed_en) begin
            if (is_digit && (feed_sub != SUB_JUNK)) begin
                o_sub          = SUB_DIG;
                o_flags.digits = 1'b1;
                if (prod > {3'b000, MagCap}) begin
                    o_value = MagCap;
                end else begin
                    o_value = prod[VAL_W-1:0];
                end
            end else if ((feed_sub == SUB_LEAD) && is_ws(i_byte)) begin
                o_sub = SUB_LEAD;
            end else if ((feed_sub == SUB_LEAD) && (i_byte == CH_PLUS)) begin
                o_sub = SUB_SIGN;
            end else if ((feed_sub == SUB_LEAD) && (i_byte == CH_MINUS)) begin
                o_sub            = SUB_SIGN;
                o_flags.negative = 1'b1;
            end else begin
                o_sub = SUB_JUNK;
            end
        end
    end

endmodule

// ===== rtl/core/resp_request_tokenizer.sv =====
// Top level of the request tokenizer: parse state, result register, handshakes.
// Depends on rrt_pkg and rrt_num_line.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_ready    i_data_byte, i_end_of_message
//   result    out        o_valid / i_ready    o_token_byte .. o_parse_error
//
// While o_ready is high one byte is taken per cycle, giving zero or one result.
// The per-byte cost is one decimal multiply-by-ten, saturate and compare.
// o_ready is high while the result register is empty or being taken this cycle.
// Reset (synchronous, active low) clears all parse state and the result valid.
// A stalled result holds its register; no input beat is taken until it leaves.
module resp_request_tokenizer import rrt_pkg::*; #(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_message,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_token_byte,
    output logic       o_byte_valid,
    output logic       o_token_first,
    output logic       o_token_last,
    output logic       o_token_abort,
    output logic       o_message_done,
    output logic       o_parse_error
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PLAIN,
        PH_CNT,
        PH_DOLLAR,
        PH_LEN,
        PH_PAYLOAD,
        PH_SKIP,
        PH_STOP
    } t_phase;

    t_phase                r_phase, n_phase;
    t_sub                  r_sub, n_sub;
    t_line_flags           r_flags, n_flags;
    logic [COUNT_BITS:0]   r_value, n_value;
    logic [COUNT_BITS-1:0] r_elements, n_elements;
    logic [COUNT_BITS-1:0] r_payload, n_payload;
    logic [1:0]            r_skip, n_skip;
    logic                  r_token_open, n_token_open;
    logic                  r_error, n_error;

    logic                  r_out_valid;
    logic [7:0]            r_byte;
    logic                  r_bvalid, r_first, r_last, r_abort, r_done, r_perr;

    logic       accept;
    logic       have, res_bvalid, res_first, res_last, res_abort;
    logic [7:0] res_byte;
    logic       c_ws;

    t_sub                line_sub;
    t_line_flags         line_flags;
    logic [COUNT_BITS:0] line_value;
    t_line_stat          line_stat;

    rrt_num_line #(
        .COUNT_BITS (COUNT_BITS)
    ) u_num_line (
        .i_byte  (i_data_byte),
        .i_sub   (r_sub),
        .i_flags (r_flags),
        .i_value (r_value),
        .o_sub   (line_sub),
        .o_flags (line_flags),
        .o_value (line_value),
        .o_stat  (line_stat)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;
    assign c_ws    = is_ws(i_data_byte);

    always_comb begin
        n_phase      = r_phase;
        n_sub        = r_sub;
        n_flags      = r_flags;
        n_value      = r_value;
        n_elements   = r_elements;
        n_payload    = r_payload;
        n_skip       = r_skip;
        n_token_open = r_token_open;
        n_error      = r_error;
        have         = 1'b0;
        res_byte     = 8'h00;
        res_bvalid   = 1'b0;
        res_first    = 1'b0;
        res_last     = 1'b0;
        res_abort    = 1'b0;

        unique case (r_phase)
            PH_IDLE, PH_PLAIN: begin
                if ((r_phase == PH_IDLE) && (i_data_byte == CH_STAR)) begin
                    n_phase = PH_CNT;
                    n_sub   = SUB_LEAD;
                    n_flags = '0;
                    n_value = '0;
                end else begin
                    n_phase = PH_PLAIN;
                    if (c_ws) begin
                        if (r_token_open) begin
                            have         = 1'b1;
                            res_last     = 1'b1;
                            n_token_open = 1'b0;
                        end
                    end else begin
                        have         = 1'b1;
                        res_byte     = i_data_byte;
                        res_bvalid   = 1'b1;
                        res_first    = !r_token_open;
                        res_last     = i_end_of_message;
                        n_token_open = 1'b1;
                    end
                end
            end
            PH_CNT: begin
                n_sub   = line_sub;
                n_flags = line_flags;
                n_value = line_value;
                if (line_stat.done) begin
                    if (line_stat.bad) begin
                        n_error = 1'b1;
                        n_phase = PH_STOP;
                    end else if (r_flags.negative || line_stat.zero) begin
                        n_phase = PH_STOP;
                    end else begin
                        n_elements = r_value[COUNT_BITS-1:0];
                        n_phase    = PH_DOLLAR;
                    end
                end
            end
            PH_DOLLAR: begin
                if (i_data_byte == CH_DOLLAR) begin
                    n_phase = PH_LEN;
                    n_sub   = SUB_LEAD;
                    n_flags = '0;
                    n_value = '0;
                end else begin
                    n_phase = PH_STOP;
                end
            end
            PH_LEN: begin
                n_sub   = line_sub;
                n_flags = line_flags;
                n_value = line_value;
                if (line_stat.done) begin
                    if (line_stat.bad) begin
                        n_error = 1'b1;
                        n_phase = PH_STOP;
                    end else if (r_flags.negative && !line_stat.zero) begin
                        n_phase = PH_STOP;
                    end else if (line_stat.zero) begin
                        // Empty bulk string: a marker-only token.
                        have      = 1'b1;
                        res_first = 1'b1;
                        res_last  = 1'b1;
                        if (r_elements != '0) begin
                            n_elements = r_elements - 1'b1;
                        end
                        n_skip  = SKIP_BYTES;
                        n_phase = PH_SKIP;
                    end else begin
                        n_payload    = r_value[COUNT_BITS-1:0];
                        n_token_open = 1'b0;
                        n_phase      = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                have = 1'b1;
                if (i_end_of_message && (r_payload > 1)) begin
                    res_abort    = r_token_open;
                    n_token_open = 1'b0;
                end else begin
                    res_byte     = i_data_byte;
                    res_bvalid   = 1'b1;
                    res_first    = !r_token_open;
                    res_last     = (r_payload <= 1);
                    n_token_open = 1'b1;
                    if (r_payload != '0) begin
                        n_payload = r_payload - 1'b1;
                    end
                    if (r_payload <= 1) begin
                        n_token_open = 1'b0;
                        if (r_elements != '0) begin
                            n_elements = r_elements - 1'b1;
                        end
                        n_skip  = SKIP_BYTES;
                        n_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (r_skip != 2'd0) begin
                    n_skip = r_skip - 2'd1;
                end
                if (r_skip <= 2'd1) begin
                    n_phase = (r_elements != '0) ? PH_DOLLAR : PH_STOP;
                end
            end
            PH_STOP: begin
                // Rest of the message is ignored.
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase

        if (i_end_of_message) begin
            have         = 1'b1;
            n_phase      = PH_IDLE;
            n_sub        = SUB_LEAD;
            n_flags      = '0;
            n_value      = '0;
            n_elements   = '0;
            n_payload    = '0;
            n_skip       = 2'd0;
            n_token_open = 1'b0;
            n_error      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_sub        <= SUB_LEAD;
            r_flags      <= '0;
            r_value      <= '0;
            r_elements   <= '0;
            r_payload    <= '0;
            r_skip       <= 2'd0;
            r_token_open <= 1'b0;
            r_error      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase      <= n_phase;
                r_sub        <= n_sub;
                r_flags      <= n_flags;
                r_value      <= n_value;
                r_elements   <= n_elements;
                r_payload    <= n_payload;
                r_skip       <= n_skip;
                r_token_open <= n_token_open;
                r_error      <= n_error;
                r_out_valid  <= have;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result beat payload; the error flag is the one left after this byte's update.
    always_ff @(posedge i_clk) begin
        if (accept && have) begin
            r_byte   <= res_byte;
            r_bvalid <= res_bvalid;
            r_first  <= res_first;
            r_last   <= res_last;
            r_abort  <= res_abort;
            r_done   <= i_end_of_message;
            r_perr   <= i_end_of_message && (r_error || (
                            ((r_phase == PH_CNT) || (r_phase == PH_LEN))
                            && line_stat.done && line_stat.bad));
        end
    end

    assign o_valid        = r_out_valid;
    assign o_token_byte   = r_byte;
    assign o_byte_valid   = r_bvalid;
    assign o_token_first  = r_first;
    assign o_token_last   = r_last;
    assign o_token_abort  = r_abort;
    assign o_message_done = r_done;
    assign o_parse_error  = r_perr;

endmodule

// ===== tb/sv/resp_request_tokenizer_test.sv =====
// Self-checking testbench for resp_request_tokenizer: directed and random messages, with
// the expected result beats predicted in the testbench itself and checked in order.
// Depends on rrt_pkg and the tokenizer RTL only.
`timescale 1ns / 100ps

module resp_request_tokenizer_test;
    import rrt_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    localparam longint unsigned POS_MAX = (64'd1 << COUNT_BITS_DEF) - 64'd1;
    localparam longint unsigned MAG_CAP = POS_MAX + 64'd2;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_PLAIN,
        PH_COUNT,
        PH_DOLLAR,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_SKIP,
        PH_STOP
    } t_parse_phase;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_SPARSE,
        RX_PERIODIC
    } t_stall_mode;

    typedef struct packed {
        logic [7:0] tok_byte;
        logic       byte_valid;
        logic       tok_first;
        logic       tok_last;
        logic       tok_abort;
        logic       msg_done;
        logic       parse_error;
    } t_token_beat;

    typedef logic [7:0] t_byte_q[$];

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic       i_end_of_message;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_token_byte;
    logic       o_byte_valid;
    logic       o_token_first;
    logic       o_token_last;
    logic       o_token_abort;
    logic       o_message_done;
    logic       o_parse_error;

    resp_request_tokenizer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_token_byte     (o_token_byte),
        .o_byte_valid     (o_byte_valid),
        .o_token_first    (o_token_first),
        .o_token_last     (o_token_last),
        .o_token_abort    (o_token_abort),
        .o_message_done   (o_message_done),
        .o_parse_error    (o_parse_error)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Tokenizer state as the testbench tracks it.
    t_parse_phase                tk_phase;
    t_sub                        tk_sub;
    logic                        tk_cr;
    logic                        tk_negative;
    logic                        tk_digits;
    logic [31:0]                 tk_value;
    logic [COUNT_BITS_DEF-1:0]   tk_elements;
    logic [COUNT_BITS_DEF-1:0]   tk_payload;
    logic [1:0]                  tk_skip;
    logic                        tk_open;
    logic                        tk_error;

    t_token_beat expected_beats[$];

    int  mismatches;
    int  beats_checked;
    int  bytes_sent;
    int  bytes_parsed;
    int  messages_sent;
    int  aborts_seen;
    int  errors_seen;
    int  empties_seen;
    int  holds_done;
    int  burst_left;
    int  quiet_cycles;
    bit  hold_request;

    function automatic bit is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic void add_byte(ref t_byte_q m, input logic [7:0] b);
        m.insert(m.size(), b);
    endfunction

    function automatic void clear_number();
        tk_cr       = 1'b0;
        tk_value    = '0;
        tk_negative = 1'b0;
        tk_digits   = 1'b0;
    endfunction

    function automatic void clear_tokenizer_state();
        clear_number();
        tk_phase    = PH_IDLE;
        tk_sub      = SUB_LEAD;
        tk_elements = '0;
        tk_payload  = '0;
        tk_skip     = '0;
        tk_open     = 1'b0;
        tk_error    = 1'b0;
    endfunction

    // One character of a count or length line, read the way stoi reads it.
    function automatic t_sub feed_number(input t_sub sub, input logic [7:0] c);
        longint unsigned acc;
        if ((c >= CH_ZERO) && (c <= CH_NINE) && (sub != SUB_JUNK)) begin
            acc = 64'(tk_value) * 64'd10 + 64'(c - CH_ZERO);
            if (acc > MAG_CAP) acc = MAG_CAP;
            tk_value  = acc[31:0];
            tk_digits = 1'b1;
            return SUB_DIG;
        end
        if (sub == SUB_LEAD) begin
            if (is_blank(c)) return SUB_LEAD;
            if (c == CH_PLUS) return SUB_SIGN;
            if (c == CH_MINUS) begin
                tk_negative = 1'b1;
                return SUB_SIGN;
            end
        end
        return SUB_JUNK;
    endfunction

    // Returns 1 when CR LF closes the line. A CR is held back until the next byte
    // shows whether it starts the line end or is an ordinary character.
    function automatic bit feed_line(input logic [7:0] c);
        t_sub sub;
        sub = tk_sub;
        if (tk_cr) begin
            if (c == CH_LF) begin
                tk_cr = 1'b0;
                return 1'b1;
            end
            sub = feed_number(sub, CH_CR);
            if (c != CH_CR) begin
                tk_cr = 1'b0;
                sub = feed_number(sub, c);
            end
        end else if (c == CH_CR) begin
            tk_cr = 1'b1;
        end else begin
            sub = feed_number(sub, c);
        end
        tk_sub = sub;
        return 1'b0;
    endfunction

    function automatic bit line_invalid();
        if (!tk_digits) return 1'b1;
        if (tk_negative) return 64'(tk_value) > POS_MAX + 64'd1;
        return 64'(tk_value) > POS_MAX;
    endfunction

    function automatic bit tokenize_byte(input logic [7:0] c, input logic eom,
                                         output t_token_beat beat);
        bit have;
        bit star_taken;
        have       = 1'b0;
        star_taken = 1'b0;
        beat       = '0;
        if (tk_phase == PH_IDLE) begin
            if (c == CH_STAR) begin
                clear_number();
                tk_phase   = PH_COUNT;
                tk_sub     = SUB_LEAD;
                star_taken = 1'b1;
            end else begin
                tk_phase = PH_PLAIN;
            end
        end
        if (!star_taken) begin
            case (tk_phase)
                PH_PLAIN: begin
                    if (is_blank(c)) begin
                        if (tk_open) begin
                            have          = 1'b1;
                            beat.tok_last = 1'b1;
                            tk_open       = 1'b0;
                        end
                    end else begin
                        have            = 1'b1;
                        beat.tok_byte   = c;
                        beat.byte_valid = 1'b1;
                        beat.tok_first  = !tk_open;
                        beat.tok_last   = eom;
                        tk_open         = 1'b1;
                    end
                end
                PH_COUNT: begin
                    if (feed_line(c)) begin
                        if (line_invalid()) begin
                            tk_error = 1'b1;
                            tk_phase = PH_STOP;
                        end else if (tk_negative || (tk_value == 0)) begin
                            tk_phase = PH_STOP;
                        end else begin
                            tk_elements = tk_value[COUNT_BITS_DEF-1:0];
                            tk_phase    = PH_DOLLAR;
                        end
                    end
                end
                PH_DOLLAR: begin
                    if (c == CH_DOLLAR) begin
                        clear_number();
                        tk_phase = PH_LENGTH;
                        tk_sub   = SUB_LEAD;
                    end else begin
                        tk_phase = PH_STOP;
                    end
                end
                PH_LENGTH: begin
                    if (feed_line(c)) begin
                        if (line_invalid()) begin
                            tk_error = 1'b1;
                            tk_phase = PH_STOP;
                        end else if (tk_negative && (tk_value != 0)) begin
                            tk_phase = PH_STOP;
                        end else if (tk_value == 0) begin
                            // An empty payload still produces one marker beat.
                            have           = 1'b1;
                            beat.tok_first = 1'b1;
                            beat.tok_last  = 1'b1;
                            if (tk_elements != 0) tk_elements--;
                            tk_skip  = SKIP_BYTES;
                            tk_phase = PH_SKIP;
                        end else begin
                            tk_payload = tk_value[COUNT_BITS_DEF-1:0];
                            tk_open    = 1'b0;
                            tk_phase   = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (eom && (tk_payload > 1)) begin
                        have           = 1'b1;
                        beat.tok_abort = tk_open;
                        tk_open        = 1'b0;
                    end else begin
                        have            = 1'b1;
                        beat.tok_byte   = c;
                        beat.byte_valid = 1'b1;
                        beat.tok_first  = !tk_open;
                        beat.tok_last   = (tk_payload <= 1);
                        tk_open         = 1'b1;
                        if (tk_payload != 0) tk_payload--;
                        if (tk_payload == 0) begin
                            tk_open = 1'b0;
                            if (tk_elements != 0) tk_elements--;
                            tk_skip  = SKIP_BYTES;
                            tk_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (tk_skip != 0) tk_skip--;
                    if (tk_skip == 0) tk_phase = (tk_elements != 0) ? PH_DOLLAR : PH_STOP;
                end
                default: ;
            endcase
        end
        if (eom) begin
            have             = 1'b1;
            beat.msg_done    = 1'b1;
            beat.parse_error = tk_error;
            clear_tokenizer_state();
        end
        return have;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatches++;
        $display("mismatch on result beat %0d: %s got %0h expected %0h",
                 beats_checked, what, got, want);
    endtask

    // The sender works in bursts; valid stays high across back-to-back beats.
    task automatic send_byte(input logic [7:0] b, input logic eom);
        t_token_beat beat;
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 16);
        end
        i_valid          <= 1'b1;
        i_data_byte      <= b;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        burst_left--;
        bytes_sent++;
        if (tk_phase != PH_STOP) bytes_parsed++;
        if (tokenize_byte(b, eom, beat)) begin
            expected_beats.insert(expected_beats.size(), beat);
            if (beat.tok_abort) aborts_seen++;
            if (beat.parse_error) errors_seen++;
            if (beat.tok_first && beat.tok_last && !beat.byte_valid) empties_seen++;
        end
    endtask

    task automatic send_message(input t_byte_q m);
        for (int i = 0; i < m.size(); i++) send_byte(m[i], i == m.size() - 1);
        messages_sent++;
    endtask

    // In directed text a '|' stands for CR LF and a '^' for a lone CR.
    function automatic void put_text(ref t_byte_q m, input string s);
        for (int i = 0; i < s.len(); i++) begin
            if (s[i] == "|") begin
                add_byte(m, CH_CR);
                add_byte(m, CH_LF);
            end else if (s[i] == "^") begin
                add_byte(m, CH_CR);
            end else begin
                add_byte(m, s[i]);
            end
        end
    endfunction

    task automatic send_text(input string s);
        t_byte_q m;
        put_text(m, s);
        send_message(m);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    // A number line with the decorations stoi accepts: leading blanks, a sign, junk.
    function automatic void put_number_line(ref t_byte_q m, input longint v);
        int pad;
        pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (pad) begin
            case ($urandom_range(0, 3))
                0: add_byte(m, CH_SPACE);
                1: add_byte(m, CH_TAB);
                2: add_byte(m, CH_VT);
                default: add_byte(m, CH_FF);
            endcase
        end
        if ((v >= 0) && ($urandom_range(0, 5) == 0)) add_byte(m, CH_PLUS);
        put_text(m, $sformatf("%0d", v));
        if ($urandom_range(0, 5) == 0) add_byte(m, 8'($urandom_range(8'h61, 8'h7A)));
        add_byte(m, CH_CR);
        add_byte(m, CH_LF);
    endfunction

    function automatic void build_array(ref t_byte_q m, input int max_len);
        int count;
        int len;
        count = $urandom_range(1, 4);
        add_byte(m, CH_STAR);
        put_number_line(m, count);
        for (int e = 0; e < count; e++) begin
            add_byte(m, CH_DOLLAR);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, max_len)
                                              : $urandom_range(0, 6);
            put_number_line(m, len);
            repeat (len) add_byte(m, 8'($urandom));
            if ($urandom_range(0, 4) == 0) begin
                add_byte(m, 8'($urandom));
                add_byte(m, 8'($urandom));
            end else begin
                add_byte(m, CH_CR);
                add_byte(m, CH_LF);
            end
        end
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 4)) add_byte(m, 8'($urandom));
    endfunction

    function automatic void build_plain(ref t_byte_q m);
        int ntok;
        logic [7:0] c;
        ntok = $urandom_range(1, 5);
        if ($urandom_range(0, 3) == 0) add_byte(m, pick_blank());
        for (int t = 0; t < ntok; t++) begin
            if (t != 0) repeat ($urandom_range(1, 3)) add_byte(m, pick_blank());
            repeat ($urandom_range(1, 6)) begin
                do begin
                    c = $urandom_range(0, 1) ? 8'($urandom_range(8'h21, 8'h7E))
                                             : 8'($urandom);
                end while (is_blank(c));
                add_byte(m, c);
            end
        end
        if ($urandom_range(0, 1)) add_byte(m, pick_blank());
    endfunction

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat ($urandom_range(2, 10)) @(posedge i_clk);
    endtask

    task automatic test_plain_tokens();
        t_byte_q m;
        send_text("SET key  value|");
        send_text("x");
        send_text("ab\tc d ");
        m = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
        send_message(m);
        m = '{8'h00, 8'hFF, CH_SPACE, 8'h80, 8'h7F};
        send_message(m);
    endtask

    task automatic test_array_directed();
        send_text("*2|$3|SET|$0||");
        send_text("*1|$-1|");
        send_text("*0|trailing");
        send_text("*-3|");
        send_text("*|");
        send_text("*-|");
        send_text("*2147483648|$1|A|");
        send_text("*-2147483649|");
        send_text("*-2147483648|");
        send_text("*99999999999999|");
        send_text("*2147483647|$1|A|$2|BC|");
        send_text("*1|$5|ab");
        send_text("*1|$4|Q");
        send_text("*1|$1|K");
        send_text("*1^2|$1|Z|");
        send_text("*1^^|$1|Z|");
        send_text("*12");
        send_text("*1|$3");
        send_text("*1|#3|abc|");
        send_text("*1|$-0||");
        send_text("* +2xy|$ 3z|abc|$+0|  ");
        send_text("*1|$2147483648|xy");
        send_text("*1|$2147483647|abc");
        send_text("*");
    endtask

    // Mostly well-formed arrays with random content, plus plain text, damaged
    // arrays, numbers at the range limits and raw noise.
    task automatic test_random_traffic(input int byte_budget);
        t_byte_q m;
        int kind;
        int start;
        int pos;
        longint limit_vals[9];
        limit_vals = '{64'sd0, 64'sd1, -64'sd1, 64'sd2147483647, 64'sd2147483648,
                       -64'sd2147483648, -64'sd2147483649, 64'sd4294967296,
                       64'sd99999999999};
        start = bytes_parsed;
        while (bytes_parsed - start < byte_budget) begin
            m.delete();
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                build_array(m, 24);
            end else if (kind < 67) begin
                build_plain(m);
            end else if (kind < 77) begin
                build_array(m, 24);
                if (m.size() > 1) m = m[0:$urandom_range(1, m.size() - 1) - 1];
            end else if (kind < 85) begin
                build_array(m, 12);
                repeat ($urandom_range(1, 2)) begin
                    pos = $urandom_range(0, m.size() - 1);
                    m[pos] = 8'($urandom);
                end
            end else if (kind < 93) begin
                add_byte(m, CH_STAR);
                if ($urandom_range(0, 1)) begin
                    put_number_line(m, limit_vals[$urandom_range(0, 8)]);
                    put_text(m, "$1|A|");
                end else begin
                    put_number_line(m, 1);
                    add_byte(m, CH_DOLLAR);
                    put_number_line(m, limit_vals[$urandom_range(0, 8)]);
                    repeat ($urandom_range(0, 5)) add_byte(m, 8'($urandom));
                end
            end else begin
                repeat ($urandom_range(1, 12)) add_byte(m, 8'($urandom));
                if ($urandom_range(0, 1)) m[0] = CH_STAR;
            end
            send_message(m);
            if ($urandom_range(0, 39) == 0) wait_for_drain();
        end
    endtask

    // The receiver stops taking results for a long stretch while bytes keep coming,
    // so the result register fills and the input side must stall.
    task automatic test_receiver_hold();
        t_byte_q m;
        hold_request = 1'b1;
        repeat (6) begin
            m.delete();
            if ($urandom_range(0, 1)) build_plain(m);
            else build_array(m, 8);
            send_message(m);
        end
    endtask

    task automatic test_drain_pause();
        t_byte_q m;
        build_array(m, 10);
        send_message(m);
        wait_for_drain();
        send_text("*1|$2|ok|");
        wait_for_drain();
    endtask

    always @(posedge i_clk) begin : result_check
        t_token_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            beats_checked++;
            if (expected_beats.size() == 0) begin
                report_mismatch("result with nothing expected, token_byte", o_token_byte, 8'h00);
            end else begin
                want = expected_beats.pop_front();
                if (o_token_byte !== want.tok_byte)
                    report_mismatch("token_byte", o_token_byte, want.tok_byte);
                if (o_byte_valid !== want.byte_valid)
                    report_mismatch("byte_valid", o_byte_valid, want.byte_valid);
                if (o_token_first !== want.tok_first)
                    report_mismatch("token_first", o_token_first, want.tok_first);
                if (o_token_last !== want.tok_last)
                    report_mismatch("token_last", o_token_last, want.tok_last);
                if (o_token_abort !== want.tok_abort)
                    report_mismatch("token_abort", o_token_abort, want.tok_abort);
                if (o_message_done !== want.msg_done)
                    report_mismatch("message_done", o_message_done, want.msg_done);
                if (o_parse_error !== want.parse_error)
                    report_mismatch("parse_error", o_parse_error, want.parse_error);
            end
        end
    end

    initial begin : ready_pattern
        t_stall_mode mode;
        int          mode_left;
        int          hold_left;
        int          tick;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_stall_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                case (mode)
                    RX_ALWAYS:   i_ready <= 1'b1;
                    RX_MOSTLY:   i_ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE:   i_ready <= ($urandom_range(0, 9) < 3);
                    default:     i_ready <= ((tick % 5) < 3);
                endcase
            end
        end
    end

    // Counts cycles in which work is pending but no beat moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles = 0;
        else if (i_valid || (expected_beats.size() != 0))
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles, %0d results outstanding",
                     quiet_cycles, expected_beats.size());
            $display("resp_request_tokenizer_test NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_data_byte      <= 8'h00;
        i_end_of_message <= 1'b0;
        mismatches    = 0;
        beats_checked = 0;
        bytes_sent    = 0;
        bytes_parsed  = 0;
        messages_sent = 0;
        aborts_seen   = 0;
        errors_seen   = 0;
        empties_seen  = 0;
        holds_done    = 0;
        burst_left    = 0;
        quiet_cycles  = 0;
        hold_request  = 1'b0;
        clear_tokenizer_state();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_plain_tokens();
        test_array_directed();
        test_random_traffic(330);
        test_receiver_hold();
        test_drain_pause();
        test_random_traffic(330);

        i_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("run covered %0d messages, %0d bytes (%0d parsed), %0d result beats checked",
                 messages_sent, bytes_sent, bytes_parsed, beats_checked);
        $display("with %0d truncated payloads, %0d parse errors, %0d empty payloads, %0d holds",
                 aborts_seen, errors_seen, empties_seen, holds_done);
        if (mismatches == 0) begin
            $display("resp_request_tokenizer_test OK");
        end else begin
            $display("resp_request_tokenizer_test NOT OK");
        end
        $finish;
    end

endmodule
